// ===== hw/rtl/nfia_pkg.sv =====
// Package for the next-fit identifier allocator.
// Sizes, function codes, state encoding and the controller/datapath structs.
// No dependencies.
`timescale 1ns / 1ps

package nfia_pkg;

	localparam int ID_COUNT = 256;
	localparam int ID_W     = $clog2(ID_COUNT);
	localparam int WORD_W   = 32;
	localparam int WORDS    = ID_COUNT / WORD_W;
	localparam int WI_W     = $clog2(WORDS);
	localparam int BIT_W    = $clog2(WORD_W);
	localparam int CNT_W    = $clog2(WORDS + 1);

	// A scan visits every word once, then the start word again for its low bits.
	localparam logic [CNT_W-1:0] LAST_VISIT = CNT_W'(WORDS);

	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	typedef struct packed {
		logic do_free;
		logic start;
		logic step;
		logic load;
	} cmd_t;

	typedef struct packed {
		logic hit;
		logic miss;
	} status_t;

endpackage

// ===== hw/rtl/nfia_dp.sv =====
// Datapath of the identifier allocator: used-map words, pointer, scan position,
// one-word free search and the result register. Depends on nfia_pkg.
`timescale 1ns / 1ps

module nfia_dp (
	input  logic                    clk,
	input  logic                    arst_n,
	input  nfia_pkg::cmd_t          cmd,
	input  logic [nfia_pkg::ID_W-1:0] release_id,
	output nfia_pkg::status_t       st,
	output logic [nfia_pkg::ID_W-1:0] granted_id,
	output logic                    exhausted
);

	logic [nfia_pkg::WORD_W-1:0] used_q [nfia_pkg::WORDS];
	logic [nfia_pkg::ID_W-1:0]   last_q;
	logic [nfia_pkg::BIT_W-1:0]  start_q;
	logic [nfia_pkg::WI_W-1:0]   wi_q;
	logic [nfia_pkg::CNT_W-1:0]  cnt_q;
	logic [nfia_pkg::ID_W-1:0]   granted_q;
	logic                        exhausted_q;

	logic [nfia_pkg::ID_W-1:0]   first_id;
	logic [nfia_pkg::WORD_W-1:0] cur_word;
	logic [nfia_pkg::WORD_W-1:0] ge_mask;
	logic [nfia_pkg::WORD_W-1:0] vis_mask;
	logic [nfia_pkg::WORD_W-1:0] free_bits;
	logic [nfia_pkg::BIT_W-1:0]  bit_idx;
	logic [nfia_pkg::ID_W-1:0]   hit_id;

	// next-fit start: pointer plus one, skipping zero on wrap
	always_comb begin
		first_id = last_q + 1'b1;
		if (first_id == '0) begin
			first_id = nfia_pkg::ID_W'(1);
		end
	end

	assign cur_word = used_q[wi_q];
	assign ge_mask  = {nfia_pkg::WORD_W{1'b1}} << start_q;

	always_comb begin
		if (cnt_q == '0) begin
			vis_mask = ge_mask;
		end else if (cnt_q == nfia_pkg::LAST_VISIT) begin
			vis_mask = ~ge_mask;
		end else begin
			vis_mask = '1;
		end
		if (wi_q == '0) begin
			vis_mask[0] = 1'b0; // id 0 is reserved
		end
	end

	assign free_bits = ~cur_word & vis_mask;

	always_comb begin
		bit_idx = '0;
		for (int i = nfia_pkg::WORD_W - 1; i >= 0; i--) begin
			if (free_bits[i]) begin
				bit_idx = nfia_pkg::BIT_W'(i);
			end
		end
	end

	assign hit_id  = {wi_q, bit_idx};
	assign st.hit  = |free_bits;
	assign st.miss = ~(|free_bits) && (cnt_q == nfia_pkg::LAST_VISIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int w = 0; w < nfia_pkg::WORDS; w++) begin
				used_q[w] <= '0;
			end
			last_q  <= '0;
			start_q <= '0;
			wi_q    <= '0;
			cnt_q   <= '0;
		end else begin
			if (cmd.do_free && release_id != '0) begin
				used_q[release_id[nfia_pkg::ID_W-1:nfia_pkg::BIT_W]]
					[release_id[nfia_pkg::BIT_W-1:0]] <= 1'b0;
			end
			if (cmd.start) begin
				start_q <= first_id[nfia_pkg::BIT_W-1:0];
				wi_q    <= first_id[nfia_pkg::ID_W-1:nfia_pkg::BIT_W];
				cnt_q   <= '0;
			end
			if (cmd.step) begin
				wi_q  <= wi_q + 1'b1;
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.load && st.hit) begin
				used_q[wi_q][bit_idx] <= 1'b1;
				last_q                <= hit_id;
			end
		end
	end

	// result register, payload only
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			granted_q   <= st.hit ? hit_id : '0;
			exhausted_q <= ~st.hit;
		end
	end

	assign granted_id = granted_q;
	assign exhausted  = exhausted_q;

endmodule

// ===== hw/rtl/nfia_ctrl.sv =====
// Controller of the identifier allocator: idle/scan state machine and the
// result valid flag. Depends on nfia_pkg.
`timescale 1ns / 1ps

module nfia_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 func,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  nfia_pkg::status_t    st,
	output nfia_pkg::cmd_t       cmd
);

	nfia_pkg::state_t state_q, state_d;
	logic             out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= nfia_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			nfia_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (func == nfia_pkg::FUNC_FREE) begin
						cmd.do_free = 1'b1;
					end else begin
						cmd.start = 1'b1;
						state_d   = nfia_pkg::ST_SCAN;
					end
				end
			end
			nfia_pkg::ST_SCAN: begin
				if (st.hit || st.miss) begin
					// finish only once the result slot is free
					if (!out_valid_q || out_ready) begin
						cmd.load = 1'b1;
						state_d  = nfia_pkg::ST_IDLE;
					end
				end else begin
					cmd.step = 1'b1;
				end
			end
			default: begin
				state_d = nfia_pkg::ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

// ===== hw/rtl/next_fit_id_allocator.sv =====
// Top level of the next-fit identifier allocator: controller plus datapath,
// and the assertions. Depends on nfia_pkg, nfia_ctrl and nfia_dp.
`timescale 1ns / 1ps

//  channel | handshake            | payload
//  --------+----------------------+------------------------------------
//  input   | in_valid / in_ready  | func, release_id
//  output  | out_valid / out_ready| granted_id, exhausted
//
// A free transaction is applied as it is accepted and produces no output transaction.
// An allocate is accepted, then scans until it finds a free id or the map is exhausted,
// one 32-bit used-map word per cycle (8 words, start word visited twice).
// Reset (arst_n low) clears the used-map and pointer at once; no clearing pass.
// A result waits in the output register; frees and the next allocate are
// still taken, an allocate only stalls at its end while that register is full.
// in_ready is low for the whole scan.

module next_fit_id_allocator (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        func,
	input  logic [nfia_pkg::ID_W-1:0]   release_id,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [nfia_pkg::ID_W-1:0]   granted_id,
	output logic                        exhausted
);

	nfia_pkg::cmd_t    cmd;
	nfia_pkg::status_t st;

	nfia_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.func      (func),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.st        (st),
		.cmd       (cmd)
	);

	nfia_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.release_id (release_id),
		.st         (st),
		.granted_id (granted_id),
		.exhausted  (exhausted)
	);

`ifndef SYNTHESIS
	// an exhausted result never carries an id, a granted one is never zero
	a_result_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (exhausted == (granted_id == '0)))
		else $error("result id and exhausted flag disagree");

	// the result register loads only when the scan has concluded
	a_load_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (st.hit || st.miss))
		else $error("result loaded before scan end");

	// an accepted allocate blocks the input for at least the next cycle
	a_alloc_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && func == nfia_pkg::FUNC_ALLOC) |=> !in_ready)
		else $error("input taken during a scan");

	// the scan never steps and loads in the same cycle
	a_step_xor_load: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.step && cmd.load))
		else $error("scan step and load together");
`endif

endmodule

// ===== bench/next_fit_id_allocator_tb.sv =====
// Testbench for next_fit_id_allocator: drives allocate and free transactions,
// predicts each grant from a used-map and next-fit pointer of its own, and checks it.
// Depends on nfia_pkg and the next_fit_id_allocator RTL.
`timescale 1ns / 1ps

module next_fit_id_allocator_tb;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_WAIT  = 16;   // drain margin used by wait_idle
	localparam int IDLE_PCT    = 13;

	typedef struct packed {
		logic [nfia_pkg::ID_W-1:0] id;
		logic                      exh;
	} grant_t;

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_ready;
	logic                      func;
	logic [nfia_pkg::ID_W-1:0] release_id;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic [nfia_pkg::ID_W-1:0] granted_id;
	logic                      exhausted;

	// Predictor state: own copy of the used-map and the next-fit pointer.
	logic [nfia_pkg::ID_COUNT-1:0] pred_used = '0;
	logic [nfia_pkg::ID_W-1:0]     pred_last = '0;

	grant_t pending_grants[$];
	int     err_count  = 0;
	int     cycle_cnt  = 0;
	bit     calm       = 1'b0;  // no random idling on either side while set
	int     hold_start = 0;     // receiver hold-off request, in cycles
	int     hold_left  = 0;

	next_fit_id_allocator uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.func       (func),
		.release_id (release_id),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.granted_id (granted_id),
		.exhausted  (exhausted)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Next-fit search: upward from pointer + 1, wrapping past the top to 1, never 0.
	// Updates the predictor state on a hit; a full map leaves everything alone.
	function automatic grant_t next_fit_grant();
		int     cand;
		grant_t g;
		cand  = int'(pred_last) + 1;
		g.id  = '0;
		g.exh = 1'b1;
		if (cand >= nfia_pkg::ID_COUNT) cand = 1;
		for (int n = 0; n + 1 < nfia_pkg::ID_COUNT; n++) begin
			if (!pred_used[cand]) begin
				pred_used[cand] = 1'b1;
				pred_last       = nfia_pkg::ID_W'(cand);
				g.id            = nfia_pkg::ID_W'(cand);
				g.exh           = 1'b0;
				break;
			end
			cand++;
			if (cand >= nfia_pkg::ID_COUNT) cand = 1;
		end
		return g;
	endfunction

	// Monitor: output side checked before the input transaction of the same
	// edge is predicted; a grant can never leave on the edge its request enters.
	always @(posedge clk) begin
		grant_t exp_g;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_grants.size() == 0) begin
					$error("grant with no request outstanding: granted_id=%0d exhausted=%0b",
						granted_id, exhausted);
					err_count++;
				end else begin
					exp_g = pending_grants.pop_front();
					if (granted_id !== exp_g.id) begin
						$error("granted_id: expected %0d, actual %0d", exp_g.id, granted_id);
						err_count++;
					end
					if (exhausted !== exp_g.exh) begin
						$error("exhausted: expected %0b, actual %0b", exp_g.exh, exhausted);
						err_count++;
					end
				end
			end
			if (in_valid && in_ready) begin
				if (func == nfia_pkg::FUNC_ALLOC)
					pending_grants.push_back(next_fit_grant());
				else if (release_id != '0 && int'(release_id) < nfia_pkg::ID_COUNT)
					pred_used[release_id] = 1'b0;
			end
		end
	end

	// Receiver: random stalls, plus a long hold-off counted here on request.
	always @(posedge clk) begin
		if (hold_start != 0) begin
			hold_left  = hold_start;
			hold_start = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (calm) begin
			out_ready <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// One transaction on the input channel. Valid stays high into the next
	// call unless an idle gap drops it first.
	task automatic send_item(input logic f, input logic [nfia_pkg::ID_W-1:0] rid);
		if (!calm && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		func       <= f;
		release_id <= rid;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic alloc_one();
		send_item(nfia_pkg::FUNC_ALLOC, nfia_pkg::ID_W'($urandom));
	endtask

	// Sender pause: drop valid and let the last accepted request be booked, then
	// wait until nothing is in flight, then a drain margin for a trailing free.
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_grants.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// An identifier currently marked in the predictor, or a random one if none.
	function automatic logic [nfia_pkg::ID_W-1:0] pick_used();
		int start;
		int k;
		start = $urandom_range(nfia_pkg::ID_COUNT - 1, 1);
		for (int n = 0; n < nfia_pkg::ID_COUNT - 1; n++) begin
			k = (start - 1 + n) % (nfia_pkg::ID_COUNT - 1) + 1;
			if (pred_used[k]) return nfia_pkg::ID_W'(k);
		end
		return nfia_pkg::ID_W'($urandom);
	endfunction

	// Basic grants, frees of zero / unused / used ids, next fit past a freed hole.
	task automatic test_directed();
		repeat (3) alloc_one();                 // 1, 2, 3
		send_item(nfia_pkg::FUNC_FREE, 8'd2);
		alloc_one();                            // next fit: 4, not the hole at 2
		send_item(nfia_pkg::FUNC_FREE, 8'd0);   // zero: no effect
		send_item(nfia_pkg::FUNC_FREE, 8'hFF);  // top id, not in use
		send_item(nfia_pkg::FUNC_FREE, 8'hAA);
		send_item(nfia_pkg::FUNC_FREE, 8'h55);
		send_item(nfia_pkg::FUNC_FREE, 8'd1);
		send_item(nfia_pkg::FUNC_FREE, 8'd1);   // double free
		repeat (3) alloc_one();
		send_item(nfia_pkg::FUNC_FREE, 8'd4);
		send_item(nfia_pkg::FUNC_ALLOC, 8'hFF); // release_id ignored on allocate
		send_item(nfia_pkg::FUNC_ALLOC, 8'h00);
		wait_idle();
	endtask

	// Mixed traffic; frees mostly target live ids so the map keeps changing.
	task automatic test_random_mix(input int n_items);
		int                        done;
		logic [nfia_pkg::ID_W-1:0] rid;
		done = 0;
		while (done < n_items) begin
			if ($urandom_range(99) < 55) begin
				alloc_one();
				done++;
			end else begin
				rid = ($urandom_range(99) < 70) ? pick_used() : nfia_pkg::ID_W'($urandom);
				if (pred_used[rid]) done++;
				send_item(nfia_pkg::FUNC_FREE, rid);
			end
		end
		wait_idle();
	endtask

	// Receiver holds off while allocates keep coming: output register fills,
	// input stalls; then the sender waits for every grant.
	task automatic test_backpressure();
		calm       = 1'b1;
		hold_start = 200;
		repeat (20) alloc_one();
		calm = 1'b0;
		wait_idle();
	endtask

	// Fill the map with no idling, hit exhaustion, then punch holes so the
	// search wraps past the top.
	task automatic test_exhaust_wrap();
		calm = 1'b1;
		repeat (nfia_pkg::ID_COUNT + 3) alloc_one();
		calm = 1'b0;
		send_item(nfia_pkg::FUNC_FREE, 8'd1);
		send_item(nfia_pkg::FUNC_FREE, 8'hFF);
		send_item(nfia_pkg::FUNC_FREE, 8'd128);
		repeat (4) alloc_one();                 // the three holes in next-fit order, then exhausted
		send_item(nfia_pkg::FUNC_FREE, 8'd7);
		send_item(nfia_pkg::FUNC_FREE, 8'd3);
		repeat (3) alloc_one();
		wait_idle();
		test_random_mix(60);                    // churn on a nearly full map
	endtask

	initial begin
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		func       <= nfia_pkg::FUNC_ALLOC;
		release_id <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_mix(130);
		test_backpressure();
		test_exhaust_wrap();

		wait_idle();
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/nfia_pkg.sv
hw/rtl/nfia_dp.sv
hw/rtl/nfia_ctrl.sv
hw/rtl/next_fit_id_allocator.sv
bench/next_fit_id_allocator_tb.sv
